// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL module of the deframer.
// Expect signals named clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/wsdf_pkg.sv =====
// Types and constants for the websocket frame deframer.
// No dependencies.
`default_nettype none

package wsdf_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int OPCODE_W  = 4;
  localparam int FLEN_W    = 24;
  localparam int CAP_W     = 24;
  localparam int ACCUM_W   = 64;
  localparam int KEY_W     = 32;
  localparam int EXT_CNT_W = 4;
  localparam int KEY_CNT_W = 3;
  localparam int POS_W     = 24;

  // Defaults
  localparam int LENGTH_WIDTH_DEF = 24;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024 * 1024);

  // Length codes of header byte one
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [EXT_CNT_W-1:0] EXT16_BYTES = EXT_CNT_W'(2);
  localparam logic [EXT_CNT_W-1:0] EXT64_BYTES = EXT_CNT_W'(8);
  localparam logic [KEY_CNT_W-1:0] KEY_BYTES   = KEY_CNT_W'(4);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// ===== sv/websocket_frame_deframer_unit.sv =====
// A byte is taken into the input register, decoded, and its result written to the result register.
// Throughput: one byte per cycle while the input is not stalled; set by the header and length decode
// between the input register and the result register.
// Bytes that cause no result never wait on a stalled output.
// Reset (synchronous, rst_n low): parser expects header byte zero, the length cap
// returns to 1048576, all parser state clears and no result is pending.
// Depends on wsdf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module websocket_frame_deframer_unit #(
  parameter int LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [wsdf_pkg::CAP_W-1:0]    cfg_wr_data,
  // byte stream in
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wsdf_pkg::BYTE_W-1:0]   in_rx_byte,
  // results out
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wsdf_pkg::KIND_W-1:0]        out_kind,
  output logic [wsdf_pkg::BYTE_W-1:0]        out_data,
  output logic [wsdf_pkg::OPCODE_W-1:0]      out_opcode,
  output logic                               out_last_of_frame,
  output logic [wsdf_pkg::FLEN_W-1:0]        out_frame_length
);

  import wsdf_pkg::*;

  // Saturation value for the reported frame length
  localparam logic [ACCUM_W-1:0] LEN_MAX =
    (ACCUM_W'(1) << LENGTH_WIDTH) - ACCUM_W'(1);

  // Configuration register
  logic [CAP_W-1:0] cap_r;

  // Input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Parser state
  phase_t                phase_r, phase_nxt;
  logic [OPCODE_W-1:0]   opc_r, opc_nxt;
  logic                  mask_r, mask_nxt;
  logic [EXT_CNT_W-1:0]  ext_r, ext_nxt;
  logic [ACCUM_W-1:0]    len_r, len_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_CNT_W-1:0]  kcnt_r, kcnt_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;

  // Result register
  logic                  out_vld_r;
  kind_t                 out_kind_r;
  logic [BYTE_W-1:0]     out_data_r;
  logic [OPCODE_W-1:0]   out_opc_r;
  logic                  out_last_r;
  logic [FLEN_W-1:0]     out_flen_r;

  // Decode results
  logic                  res_vld;
  kind_t                 res_kind;
  logic [BYTE_W-1:0]     res_data;
  logic                  res_last;
  logic [ACCUM_W-1:0]    len_sat;
  logic                  len_end;
  logic                  hdr_end;
  logic                  mask_cur;
  logic [BYTE_W-1:0]     key_byte;
  logic                  proc_fire;

  // Next-state decode for the byte in the input register
  always_comb begin
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    mask_nxt  = mask_r;
    ext_nxt   = ext_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    kcnt_nxt  = kcnt_r;
    pos_nxt   = pos_r;
    res_vld   = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_data  = '0;
    res_last  = 1'b0;
    len_end   = 1'b0;
    hdr_end   = 1'b0;
    mask_cur  = mask_r;
    key_byte  = '0;

    unique case (phase_r)
      PH_HDR0: begin
        opc_nxt   = in_byte_r[OPCODE_W-1:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = in_byte_r[7];
        mask_cur = in_byte_r[7];
        key_nxt  = '0;
        len_nxt  = '0;
        if (in_byte_r[6:0] == LEN7_EXT16) begin
          ext_nxt   = EXT16_BYTES;
          phase_nxt = PH_EXT;
        end else if (in_byte_r[6:0] == LEN7_EXT64) begin
          ext_nxt   = EXT64_BYTES;
          phase_nxt = PH_EXT;
        end else begin
          len_nxt = ACCUM_W'(in_byte_r[6:0]);
          len_end = 1'b1;
        end
      end
      PH_EXT: begin
        // big-endian: shift in below what is there
        len_nxt = {len_r[ACCUM_W-BYTE_W-1:0], in_byte_r};
        ext_nxt = ext_r - EXT_CNT_W'(1);
        len_end = (ext_r == EXT_CNT_W'(1));
      end
      PH_KEY: begin
        key_nxt  = {key_r[KEY_W-BYTE_W-1:0], in_byte_r};
        kcnt_nxt = kcnt_r - KEY_CNT_W'(1);
        hdr_end  = (kcnt_r == KEY_CNT_W'(1));
      end
      PH_DATA: begin
        // first key byte sits in the top bits
        unique case (pos_r[1:0])
          2'd0:    key_byte = key_r[31:24];
          2'd1:    key_byte = key_r[23:16];
          2'd2:    key_byte = key_r[15:8];
          default: key_byte = key_r[7:0];
        endcase
        res_vld  = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_data = in_byte_r ^ key_byte;
        res_last = (ACCUM_W'({1'b0, pos_r} + (POS_W+1)'(1)) >= len_r);
        pos_nxt  = pos_r + POS_W'(1);
        if (res_last) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_HALT: begin
        // everything after an oversize length is dropped
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    // Length complete: fetch the mask key or finish the header
    if (len_end) begin
      if (mask_cur) begin
        kcnt_nxt  = KEY_BYTES;
        phase_nxt = PH_KEY;
      end else begin
        hdr_end = 1'b1;
      end
    end

    // Header complete: length check
    if (hdr_end) begin
      if (len_nxt > ACCUM_W'(cap_r)) begin
        phase_nxt = PH_HALT;
        res_vld   = 1'b1;
        res_kind  = KIND_ERROR;
      end else if (len_nxt == '0) begin
        phase_nxt = PH_HDR0;
        res_vld   = 1'b1;
        res_kind  = KIND_EMPTY;
        res_last  = 1'b1;
      end else begin
        pos_nxt   = '0;
        phase_nxt = PH_DATA;
      end
    end

    // Reported length, saturated
    len_sat = (|(len_nxt & ~LEN_MAX)) ? LEN_MAX : len_nxt;
  end

  // A byte moves on unless its result would land on a stalled, full output
  assign proc_fire = in_vld_r && (!res_vld || !out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !proc_fire;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      opc_r   <= '0;
      mask_r  <= 1'b0;
      ext_r   <= '0;
      len_r   <= '0;
      key_r   <= '0;
      kcnt_r  <= '0;
      pos_r   <= '0;
    end else if (proc_fire) begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      mask_r  <= mask_nxt;
      ext_r   <= ext_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      kcnt_r  <= kcnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_vld) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_opc_r  <= opc_r;
      out_last_r <= res_last;
      out_flen_r <= len_sat[FLEN_W-1:0];
    end
  end

  assign out_valid         = out_vld_r;
  assign out_kind          = out_kind_r;
  assign out_data          = out_data_r;
  assign out_opcode        = out_opc_r;
  assign out_last_of_frame = out_last_r;
  assign out_frame_length  = out_flen_r;

  // Checks
  `ASSERT_NEXT(a_halt_sticks, phase_r == PH_HALT, phase_r == PH_HALT)
  `ASSERT_NEXT(a_error_halts, proc_fire && res_vld && res_kind == KIND_ERROR,
               phase_r == PH_HALT && out_vld_r && out_kind_r == KIND_ERROR)
  `ASSERT_SAME(a_data_only_payload, out_vld_r && out_kind_r != KIND_PAYLOAD,
               out_data_r == '0)
  `ASSERT_SAME(a_empty_is_last, out_vld_r && out_kind_r == KIND_EMPTY, out_last_r)
  `ASSERT_SAME(a_pos_in_frame, phase_r == PH_DATA,
               len_r != '0 && ACCUM_W'(pos_r) < len_r)

endmodule

`default_nettype wire
